FILE: hdl/rrpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrpc_pkg
// Shared types, codes and the flag priority tree of the page classifier.
// ----------------------------------------------------------------------------
package rrpc_pkg;

   typedef enum logic [3:0] {
      PC_UNKNOWN     = 4'd0,
      PC_TEMP        = 4'd1,
      PC_REBUILDABLE = 4'd2,
      PC_HEADER      = 4'd3,
      PC_FULLIMAGE   = 4'd4,
      PC_NEW         = 4'd5,
      PC_CLEANOUT    = 4'd6,
      PC_NONLOGGED   = 4'd7,
      PC_NORMAL      = 4'd8
   } page_class_type;

   localparam logic [1:0] FORK_FSM  = 2'd1;
   localparam logic [1:0] FORK_INIT = 2'd3;

   localparam logic ACT_CLASSIFY = 1'b0;
   localparam logic ACT_REGISTER = 1'b1;

   typedef struct packed {
      logic [7:0]  rm;
      logic [15:0] op;
   } rrpc_key_type;

   // Search token that walks the cell row.
   typedef struct packed {
      logic         live;
      logic         hit;
      rrpc_key_type key;
   } rrpc_token_type;

   typedef struct packed {
      page_class_type cls;
      logic           lookup;
   } rrpc_pre_type;

   // Everything of the tree except the final registry lookup.
   function automatic rrpc_pre_type pre_classify(
      input logic [1:0] fork_number,
      input logic       hdr,
      input logic       tmp,
      input logic       unl,
      input logic       fpi,
      input logic       winit,
      input logic       absent,
      input logic       fresh_pg,
      input logic       clean
   );
      rrpc_pre_type r;
      logic         fresh;
      logic         is_fsm;
      logic         is_init;
      fresh   = absent | fresh_pg;
      is_fsm  = (fork_number == FORK_FSM);
      is_init = (fork_number == FORK_INIT);
      r.lookup = 1'b0;
      r.cls    = PC_UNKNOWN;
      priority if (hdr && (is_init || is_fsm || tmp || fpi || winit || fresh ||
                           clean || unl)) begin
         r.cls = PC_UNKNOWN;
      end else if (is_fsm && (fpi || winit || clean || unl)) begin
         r.cls = PC_UNKNOWN;
      end else if (fpi && winit) begin
         r.cls = PC_UNKNOWN;
      end else if ((clean || unl) && (fpi || winit)) begin
         r.cls = PC_UNKNOWN;
      end else if (is_init || tmp) begin
         r.cls = PC_TEMP;
      end else if (is_fsm) begin
         r.cls = PC_REBUILDABLE;
      end else if (hdr) begin
         r.cls = PC_HEADER;
      end else if (winit) begin
         r.cls = PC_UNKNOWN;
      end else if (fpi) begin
         r.cls = PC_FULLIMAGE;
      end else if (fresh) begin
         r.cls = PC_NEW;
      end else if (clean) begin
         r.cls = PC_CLEANOUT;
      end else if (unl) begin
         r.cls = PC_NONLOGGED;
      end else begin
         r.lookup = 1'b1;
      end
      return r;
   endfunction

endpackage

FILE: hdl/rrpc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrpc_cell
// One registry entry; compares the passing token against it and forwards it.
// ----------------------------------------------------------------------------
module rrpc_cell import rrpc_pkg::*; #(
   parameter int IDX   = 0,
   parameter int CNT_W = 7,
   parameter int IDX_W = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [CNT_W-1:0]   count,
   input  rrpc_token_type     tok_i,
   output rrpc_token_type     tok_o,
   input  logic               wr_en,
   input  logic [IDX_W-1:0]   wr_addr,
   input  rrpc_key_type       wr_key
);

   rrpc_key_type   entry_ff;
   rrpc_token_type tok_ff;
   rrpc_token_type tok_in;
   logic           match;

   // Only entries below the fill count have been written.
   assign match = (count > CNT_W'(IDX)) && (entry_ff == tok_i.key);

   always_comb begin
      tok_in     = tok_i;
      tok_in.hit = tok_i.hit | (tok_i.live & match);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.live <= 1'b0;
      end else begin
         tok_ff.live <= tok_in.live;
      end
      tok_ff.hit <= tok_in.hit;
      tok_ff.key <= tok_in.key;
      if (wr_en && (wr_addr == IDX_W'(IDX))) begin
         entry_ff <= wr_key;
      end
   end

   assign tok_o = tok_ff;

endmodule

FILE: hdl/rrpc_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrpc_chain
// Row of registry cells; a token enters at cell zero and leaves after the last.
// ----------------------------------------------------------------------------
module rrpc_chain import rrpc_pkg::*; #(
   parameter int TABLE_DEPTH = 64,
   parameter int CNT_W       = 7,
   parameter int IDX_W       = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [CNT_W-1:0]   count,
   input  rrpc_token_type     tok_i,
   output rrpc_token_type     tok_o,
   input  logic               wr_en,
   input  logic [IDX_W-1:0]   wr_addr,
   input  rrpc_key_type       wr_key
);

   rrpc_token_type tok [0:TABLE_DEPTH];

   assign tok[0] = tok_i;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      rrpc_cell #(
         .IDX   (i),
         .CNT_W (CNT_W),
         .IDX_W (IDX_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .count   (count),
         .tok_i   (tok[i]),
         .tok_o   (tok[i+1]),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_key  (wr_key)
      );
   end

   assign tok_o = tok[TABLE_DEPTH];

endmodule

FILE: hdl/redo_record_page_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// redo_record_page_classifier_core
// Classifies redo log records by fork and flags and keeps a bounded registry
// of known (resource manager id, opcode) pairs.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Word contents
//   --------+-----------+-------------------------------------------------
//   req_    | in        | one record to classify or one pair to register
//   rsp_    | out       | one result word per request word
//
// A request word that the flag tree settles alone goes straight from
// S_IDLE to S_DONE. A word that needs the registry (every registration,
// and a record of fork 0 or 2 that passes the whole tree) sends a search
// token down the row of TABLE_DEPTH cells, one cell per cycle.
// Reset clears the fill count and the control state only; the entries are
// never read before they are written, so there is no clearing pass.
// The result sits in an output register; a new request word is taken while
// an earlier result still waits there, and only a second finished result
// waits for the output register to free up.
//
module redo_record_page_classifier_core import rrpc_pkg::*; #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] rm_id, [23:8] op_code, [25:24] fork_number, [26] header_owned,
   // [27] rel_temp, [28] rel_unlogged, [29] page_image, [30] init_intent,
   // [31] no_page, [32] page_fresh, [33] cleanout, [39:34] zero
   input  logic [39:0] req_tdata,
   // [0] action
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [3:0] page_class, [4] register_ok, [7:5] zero
   output logic [7:0]  rsp_tdata
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // The control sequence: wait for a word, wait for the search token if the
   // word needs the registry, then hand the result to the output register.
   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SEARCH = 3'b010,
      S_DONE   = 3'b100
   } state_type;

   state_type      state_ff,   state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic           act_ff,     act_in;
   rrpc_key_type   key_ff,     key_in;
   page_class_type res_cls_ff, res_cls_in;
   logic           res_ok_ff,  res_ok_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [4:0]     rsp_data_ff,  rsp_data_in;

   rrpc_pre_type   pre;
   rrpc_token_type tok_launch;
   rrpc_token_type tok_done;
   rrpc_key_type   req_key;
   logic           req_fire;
   logic           room;
   logic           wr_en;

   assign req_key.rm = req_tdata[7:0];
   assign req_key.op = req_tdata[23:8];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign room       = (count_ff < CNT_W'(TABLE_DEPTH));

   // A registration always searches; a record searches only if no flag
   // or fork number decided its class first.
   always_comb begin
      pre = pre_classify(req_tdata[25:24], req_tdata[26], req_tdata[27],
                         req_tdata[28], req_tdata[29], req_tdata[30],
                         req_tdata[31], req_tdata[32], req_tdata[33]);
      if (req_tuser == ACT_REGISTER) begin
         pre.lookup = 1'b1;
         pre.cls    = PC_UNKNOWN;
      end
   end

   always_comb begin
      tok_launch.live = req_fire & pre.lookup;
      tok_launch.hit  = 1'b0;
      tok_launch.key  = req_key;
   end

   rrpc_chain #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .CNT_W       (CNT_W),
      .IDX_W       (IDX_W)
   ) u_chain (
      .clock   (clock),
      .reset   (reset),
      .count   (count_ff),
      .tok_i   (tok_launch),
      .tok_o   (tok_done),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_key  (key_ff)
   );

   // A new pair is appended at the fill count when the token comes back
   // without a hit and the table still has room.
   assign wr_en = (state_ff == S_SEARCH) && tok_done.live &&
                  (act_ff == ACT_REGISTER) && !tok_done.hit && room;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      act_in       = act_ff;
      key_in       = key_ff;
      res_cls_in   = res_cls_ff;
      res_ok_in    = res_ok_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               act_in     = req_tuser;
               key_in     = req_key;
               res_cls_in = pre.cls;
               res_ok_in  = 1'b0;
               state_in   = pre.lookup ? S_SEARCH : S_DONE;
            end
         end
         S_SEARCH: begin
            if (tok_done.live) begin
               if (act_ff == ACT_REGISTER) begin
                  res_cls_in = PC_UNKNOWN;
                  res_ok_in  = tok_done.hit | room;
               end else begin
                  res_cls_in = tok_done.hit ? PC_NORMAL : PC_UNKNOWN;
                  res_ok_in  = 1'b0;
               end
               if (wr_en) begin
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_ok_ff, res_cls_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff      <= act_in;
      key_ff      <= key_in;
      res_cls_ff  <= res_cls_in;
      res_ok_ff   <= res_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};

   // A token can only come back while the controller waits for it.
   a_token_in_search: assert property (@(posedge clock) disable iff (reset)
      tok_done.live |-> (state_ff == S_SEARCH))
      else $error("search token left the row outside a search");

   // The fill count never passes the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("registry fill count beyond table depth");

   // An append moves the fill count up by exactly one.
   a_append_count: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("append did not advance the fill count");

   // A word that needs the registry starts a search in the next cycle.
   a_launch_search: assert property (@(posedge clock) disable iff (reset)
      tok_launch.live |=> (state_ff == S_SEARCH))
      else $error("registry search not started");

   // A finished result is never dropped while the output is stalled.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("pending result overwritten");

endmodule
